### design/neuron_forward_activation_unit_defines.svh
// ----------------------------------------------------------------------------
// neuron forward activation unit assertion macros
// concurrent property shorthands on clk with arst_n as the disable
// ----------------------------------------------------------------------------
`ifndef NEURON_FORWARD_ACTIVATION_UNIT_DEFINES_SVH
`define NEURON_FORWARD_ACTIVATION_UNIT_DEFINES_SVH

// same-cycle implication
`define FNA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fna assertion failed");

// next-cycle implication
`define FNA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fna assertion failed");

`endif

### design/fna_pkg.sv
// ----------------------------------------------------------------------------
// fna_pkg
// shared types, formats and the tanh segment table of the activation unit
// ----------------------------------------------------------------------------
`default_nettype none

package fna_pkg;

	localparam int DATA_W        = 16;
	localparam int FRAC_BITS     = 12;
	localparam int ACC_WIDTH_DEF = 40;
	localparam int SEG_BITS      = 5;
	localparam int TAB_SEGMENTS  = 1 << SEG_BITS;
	localparam int TAB_IW        = SEG_BITS + 1;
	localparam int TAB_W         = FRAC_BITS + 1;
	// tanh argument limit 8.0 sits at this bit of the magnitude
	localparam int TANH_SH       = FRAC_BITS + 3;
	localparam int FRAC_W        = TANH_SH + 1 - SEG_BITS;
	localparam int ONE           = 1 << FRAC_BITS;

	typedef enum logic [1:0] {
		ACT_IDENTITY = 2'd0,
		ACT_TANH     = 2'd1,
		ACT_SIGMOID  = 2'd2,
		ACT_RELU     = 2'd3
	} act_mode_t;

	typedef enum logic [2:0] {
		S_RUN,
		S_SUM,
		S_LOOK,
		S_MUL,
		S_EMIT
	} fna_state_t;

	typedef struct packed {
		logic load;
		logic acc_add;
		logic look;
		logic mul;
		logic emit;
	} fna_cmd_t;

	// tanh(k/4) in Q.12, rounded to nearest, k = 0..32
	localparam logic [TAB_W-1:0] TANH_TAB [0:TAB_SEGMENTS] = '{
		13'd0,    13'd1003, 13'd1893, 13'd2602, 13'd3119, 13'd3475, 13'd3707,
		13'd3856, 13'd3949, 13'd4006, 13'd4041, 13'd4063, 13'd4076, 13'd4084,
		13'd4089, 13'd4091, 13'd4093, 13'd4094, 13'd4095, 13'd4095, 13'd4096,
		13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096,
		13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096
	};

endpackage

`default_nettype wire

### design/neuron_forward_activation_unit.sv
// ----------------------------------------------------------------------------
// neuron_forward_activation_unit
// one neuron forward pass: saturating multiply-accumulate and activation
// ----------------------------------------------------------------------------
// result: registered after the product register, accumulator, table lookup and
// interpolation multiply steps; a result held by the receiver stalls the emit
// throughput: one item per cycle inside a run, set by the product multiplier
// and accumulator; a last item stalls the input until its result is emitted
// reset: accumulator cleared, activation set to tanh, no result pending
`default_nettype none

module neuron_forward_activation_unit #(
	parameter int ACC_WIDTH = fna_pkg::ACC_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input items
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [15:0] prev_activation, [31:16] link_weight
	input  logic [2*fna_pkg::DATA_W-1:0] s_tdata,
	// is_last
	input  logic                         s_tlast,
	// result items
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] neuron_output
	output logic [fna_pkg::DATA_W-1:0]   m_tdata,
	// activation_mode: 0 identity, 1 tanh, 2 sigmoid, 3 relu
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_wr_data
);
	import fna_pkg::*;

	// commands from the sequencer to the datapath
	fna_cmd_t cmd;

	// sequencer: takes items, steps the activation, owns the output valid
	fna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// datapath: product register, accumulator, table and output register
	fna_datapath #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.s_tdata     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire

### design/fna_ctrl.sv
// ----------------------------------------------------------------------------
// fna_ctrl
// sequencer for accumulate, activation steps and the output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module fna_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output fna_pkg::fna_cmd_t cmd
);
	import fna_pkg::*;

	fna_state_t state_q, state_d;
	logic       acc_add_q;
	logic       out_vld_q;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RUN;
			acc_add_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			acc_add_q <= accept;
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.acc_add = acc_add_q;
		unique case (state_q)
			S_RUN: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				// final product lands in the accumulator
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_vld_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = S_RUN;
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
		accept   = s_tvalid && s_tready;
		cmd.load = accept;
	end

	assign m_tvalid = out_vld_q;

endmodule

`default_nettype wire

### design/fna_datapath.sv
// ----------------------------------------------------------------------------
// fna_datapath
// multiplier, saturating accumulator, table interpolation and output register
// ----------------------------------------------------------------------------
`default_nettype none

module fna_datapath #(
	parameter int ACC_WIDTH = fna_pkg::ACC_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fna_pkg::fna_cmd_t           cmd,
	input  logic [2*fna_pkg::DATA_W-1:0] s_tdata,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_wr_data,
	output logic [fna_pkg::DATA_W-1:0]  m_tdata
);
	import fna_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int EW     = (ACC_WIDTH > PROD_W ? ACC_WIDTH : PROD_W) + 1;
	localparam int XW     = ACC_WIDTH - FRAC_BITS;
	localparam int MW     = (XW > TANH_SH + 2) ? XW : TANH_SH + 2;

	localparam logic signed [EW-1:0] ACC_MAX =
		{{(EW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [EW-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [MW-1:0] D_MAX = MW'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [MW-1:0] D_MIN = ~D_MAX;

	act_mode_t                   mode_q;
	logic signed [PROD_W-1:0]    product_s1;
	logic signed [ACC_WIDTH-1:0] acc_q;

	logic [TAB_W-1:0]            t_lo_s1;
	logic [TAB_W-1:0]            t_diff_s1;
	logic [FRAC_W-1:0]           frac_s1;
	logic                        neg_s1;
	logic signed [DATA_W-1:0]    xsat_s1;
	logic [TAB_W+FRAC_W-1:0]     interp_s2;
	logic [DATA_W-1:0]           out_data_q;

	// accumulate
	logic signed [EW-1:0] prod_x, prod_cl, sum_x, sum_cl;

	always_comb begin
		prod_x  = EW'(product_s1);
		prod_cl = (prod_x > ACC_MAX) ? ACC_MAX : ((prod_x < ACC_MIN) ? ACC_MIN : prod_x);
		sum_x   = EW'(acc_q) + prod_cl;
		sum_cl  = (sum_x > ACC_MAX) ? ACC_MAX : ((sum_x < ACC_MIN) ? ACC_MIN : sum_x);
	end

	// table lookup
	logic signed [XW-1:0] x;
	logic                 x_neg;
	logic [XW-1:0]        x_mag;
	logic [MW-1:0]        mag_e;
	logic signed [MW-1:0] x_ext;
	logic                 is_sig;
	logic                 over;
	logic [SEG_BITS-1:0]  seg;
	logic [FRAC_W-1:0]    frac;
	logic [TAB_W-1:0]     t_lo, t_hi;
	logic signed [DATA_W-1:0] xsat;

	always_comb begin
		x      = acc_q[ACC_WIDTH-1:FRAC_BITS];
		x_neg  = x[XW-1];
		x_mag  = x_neg ? XW'(-x) : x;
		mag_e  = MW'(x_mag);
		x_ext  = MW'(x);
		is_sig = (mode_q == ACT_SIGMOID);
		if (is_sig) begin
			over = (mag_e[MW-1:TANH_SH+1] != '0);
			seg  = mag_e[TANH_SH -: SEG_BITS];
			frac = mag_e[FRAC_W-1:0];
		end else begin
			over = (mag_e[MW-1:TANH_SH] != '0);
			seg  = mag_e[TANH_SH-1 -: SEG_BITS];
			frac = {mag_e[FRAC_W-2:0], 1'b0};
		end
		if (over) begin
			t_lo = TANH_TAB[TAB_SEGMENTS];
			t_hi = TANH_TAB[TAB_SEGMENTS];
		end else begin
			t_lo = TANH_TAB[TAB_IW'(seg)];
			t_hi = TANH_TAB[TAB_IW'(seg) + TAB_IW'(1)];
		end
		if (x_ext > D_MAX) begin
			xsat = D_MAX[DATA_W-1:0];
		end else if (x_ext < D_MIN) begin
			xsat = D_MIN[DATA_W-1:0];
		end else begin
			xsat = x_ext[DATA_W-1:0];
		end
	end

	// final combine
	logic [TAB_W-1:0]         tv;
	logic signed [TAB_W:0]    ts;
	logic signed [TAB_W+1:0]  sig_sum;
	logic signed [TAB_W+1:0]  sig_y;
	logic [DATA_W-1:0]        y;

	always_comb begin
		tv      = t_lo_s1 + interp_s2[TAB_W+FRAC_W-1:FRAC_W];
		ts      = neg_s1 ? -$signed({1'b0, tv}) : $signed({1'b0, tv});
		sig_sum = (TAB_W + 2)'(ONE) + (TAB_W + 2)'(ts);
		sig_y   = sig_sum >>> 1;
		unique case (mode_q)
			ACT_TANH:     y = DATA_W'(ts);
			ACT_SIGMOID:  y = DATA_W'(sig_y);
			ACT_RELU:     y = xsat_s1[DATA_W-1] ? '0 : xsat_s1;
			ACT_IDENTITY: y = xsat_s1;
			default:      y = xsat_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ACT_TANH;
			acc_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= act_mode_t'(cfg_wr_data);
			end
			if (cmd.look) begin
				acc_q <= '0;
			end else if (cmd.acc_add) begin
				acc_q <= sum_cl[ACC_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			product_s1 <= $signed(s_tdata[DATA_W-1:0]) * $signed(s_tdata[PROD_W-1:DATA_W]);
		end
		if (cmd.look) begin
			t_lo_s1   <= t_lo;
			t_diff_s1 <= t_hi - t_lo;
			frac_s1   <= frac;
			neg_s1    <= x_neg;
			xsat_s1   <= xsat;
		end
		if (cmd.mul) begin
			interp_s2 <= t_diff_s1 * frac_s1;
		end
		if (cmd.emit) begin
			out_data_q <= y;
		end
	end

	assign m_tdata = out_data_q;

endmodule

`default_nettype wire

### design/fna_checker.sv
// ----------------------------------------------------------------------------
// fna_checker
// port-level checks on the activation unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "neuron_forward_activation_unit_defines.svh"

module fna_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);

	// a stalled result holds
	`FNA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// the last item of a run stops intake while the activation runs
	`FNA_ASSERT_NEXT(a_last_stall, s_tvalid && s_tready && s_tlast, !s_tready)

	// items inside a run stream without a gap
	`FNA_ASSERT_NEXT(a_run_flow, s_tvalid && s_tready && !s_tlast, s_tready)

endmodule

bind neuron_forward_activation_unit fna_checker u_fna_checker (.*);

`default_nettype wire
